/* rtl/elpm_pkg.sv */
// elpm_pkg: shared constants, codes and item types for the edit-list position mapper.
// No dependencies; imported by the interfaces, the RAM users and the top level.
package elpm_pkg;

    localparam int NUM_CLIPS = 32;
    localparam int CLIP_AW   = $clog2(NUM_CLIPS);
    localparam int CLIP_CW   = $clog2(NUM_CLIPS + 1);
    localparam int MAX_RUNS  = 32;
    localparam int RUN_AW    = $clog2(MAX_RUNS);
    localparam int RUN_CW    = $clog2(MAX_RUNS + 1);
    localparam int ACC_W     = 40;
    localparam int VAL_W     = 31;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_LENGTHS = 2'd1,
        CMD_SEEK    = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SEEK_BEGIN = 2'd0,
        SEEK_CUR   = 2'd1,
        SEEK_END   = 2'd2,
        SEEK_RSVD  = 2'd3
    } t_seek_mode;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_AC,
        ST_BASE,
        ST_MAP_RD,
        ST_MAP_EV,
        ST_MAP_END,
        ST_MAP_LS,
        ST_SEEK_OUT,
        ST_WAIT,
        ST_RD_RD,
        ST_RD_EV,
        ST_RD_NX,
        ST_RD_FIN,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [4:0]        clip_slot;
        logic [30:0]       clip_first;
        logic [30:0]       clip_last;
        logic [30:0]       edited_length_in;
        logic [30:0]       original_length_in;
        logic signed [31:0] offset;
        t_seek_mode        seek_mode;
        logic [30:0]       count;
    } t_in_item;

    typedef struct packed {
        logic [30:0] position;
        logic [30:0] file_address;
        logic [4:0]  clip_number;
        logic [30:0] run_length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [30:0] total;
        logic [30:0] addr;
        logic [30:0] len;
    } t_run;

endpackage

/* rtl/elpm_in_if.sv */
// elpm_in_if: command channel, valid/ready with one command item.
// Depends on elpm_pkg.
interface elpm_in_if import elpm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/elpm_out_if.sv */
// elpm_out_if: result channel, valid/ready with one result item.
// Depends on elpm_pkg.
interface elpm_out_if import elpm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/edit_list_position_mapper.sv */
// edit_list_position_mapper: top level, command sequencer over the clip table and run buffer.
// Depends on elpm_pkg, elpm_in_if, elpm_out_if and elpm_ram.
//
//   channel   dir   handshake      payload
//   i_cmd     in    valid/ready    t_in_item  (command and its operands)
//   o_res     out   valid/ready    t_out_item (one per seek; per read run, or one if none)
//
// A seek walks the clip table's single read port, a read then an evaluate state per
// entry: it sums the clips before the current one, then maps the target unless it is a
// zero SEEK_CUR. A read fills the run buffer, then delivers its runs one at a time. Reset
// clears the state, lengths, position, current clip, result valid and clip table valid bits.
// One item at a time; a stalled result holds the block until taken.
module edit_list_position_mapper import elpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    elpm_in_if.sink    i_cmd,
    elpm_out_if.source o_res
);
    t_state r_state, n_state;
    logic [30:0] r_et, n_et, r_ot, n_ot, r_fp, n_fp;
    logic [CLIP_CW-1:0] r_cc, n_cc, r_i, n_i;
    logic signed [ACC_W-1:0] r_acc, n_acc, r_target, n_target;
    logic signed [31:0] r_off, n_off;
    t_seek_mode r_mode, n_mode;
    logic [30:0] r_rep, n_rep, r_last_end, n_last_end;
    logic [31:0] r_rfp, n_rfp;
    logic [30:0] r_rem, n_rem, r_total, n_total;
    logic [RUN_CW-1:0] r_n, n_n, r_k, n_k;
    t_out_item r_out, n_out;
    logic r_out_valid, n_out_valid;
    logic [NUM_CLIPS-1:0] r_valid, n_valid;
    logic r_rd_valid;

    logic tab_we;
    logic [CLIP_AW-1:0] tab_waddr, tab_raddr;
    logic [30:0] tab_wstart, tab_wend, ram_start, ram_end, start_q, end_q;
    logic buf_we;
    logic [RUN_AW-1:0] buf_waddr, buf_raddr;
    t_run buf_wdata, buf_q;

    elpm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_CLIPS)) u_start (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wstart),
        .i_raddr(tab_raddr), .o_rdata(ram_start)
    );
    elpm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_CLIPS)) u_end (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wend),
        .i_raddr(tab_raddr), .o_rdata(ram_end)
    );
    elpm_ram #(.WIDTH($bits(t_run)), .DEPTH(MAX_RUNS)) u_runs (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_raddr(buf_raddr), .o_rdata(buf_q)
    );

    assign start_q = r_rd_valid ? ram_start : '0;
    assign end_q   = r_rd_valid ? ram_end   : '0;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_et        <= '0;
            r_ot        <= '0;
            r_fp        <= '0;
            r_cc        <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_et        <= n_et;
            r_ot        <= n_ot;
            r_fp        <= n_fp;
            r_cc        <= n_cc;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= r_valid[tab_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_acc      <= n_acc;
        r_target   <= n_target;
        r_off      <= n_off;
        r_mode     <= n_mode;
        r_rep      <= n_rep;
        r_last_end <= n_last_end;
        r_rfp      <= n_rfp;
        r_rem      <= n_rem;
        r_total    <= n_total;
        r_n        <= n_n;
        r_k        <= n_k;
        r_out      <= n_out;
    end

    always_comb begin
        logic signed [32:0] len;
        logic signed [ACC_W-1:0] lenx, s, was, tgt, pos_end, addr;
        logic signed [33:0] run, rem;
        logic [31:0] rfp_new;
        logic [30:0] total_new;
        logic [CLIP_CW-1:0] cc_next;

        n_state = r_state;  n_et = r_et;  n_ot = r_ot;  n_fp = r_fp;  n_cc = r_cc;
        n_i = r_i;  n_acc = r_acc;  n_target = r_target;  n_off = r_off;
        n_mode = r_mode;  n_rep = r_rep;  n_last_end = r_last_end;  n_rfp = r_rfp;
        n_rem = r_rem;  n_total = r_total;  n_n = r_n;  n_k = r_k;
        n_out = r_out;  n_out_valid = r_out_valid;  n_valid = r_valid;
        tab_we = 1'b0;  tab_waddr = r_i[CLIP_AW-1:0];
        tab_wstart = r_ot;  tab_wend = r_ot - 31'd1;
        tab_raddr = r_i[CLIP_AW-1:0];
        buf_we = 1'b0;  buf_waddr = r_n[RUN_AW-1:0];  buf_raddr = r_k[RUN_AW-1:0];
        buf_wdata = '0;

        len  = $signed({2'b00, end_q}) - $signed({2'b00, start_q}) + 33'sd1;
        lenx = ACC_W'(len);
        s    = (r_cc < CLIP_CW'(NUM_CLIPS)) ? $signed({{(ACC_W-31){1'b0}}, start_q}) : '0;
        was  = r_acc + $signed({{(ACC_W-31){1'b0}}, r_fp}) - s;
        tgt  = ACC_W'(r_off);
        pos_end = r_acc + lenx;
        addr = $signed({{(ACC_W-31){1'b0}}, start_q}) + r_target - r_acc;
        run  = $signed({3'b000, end_q}) - $signed({2'b00, r_rfp}) + 34'sd1;
        rem  = $signed({3'b000, r_rem});
        if (rem < run) begin
            run = rem;
        end
        rfp_new   = r_rfp + run[31:0];
        total_new = r_total + run[30:0];
        cc_next   = r_cc + CLIP_CW'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.data.command)
                        CMD_LOAD: begin
                            if (int'(i_cmd.data.clip_slot) < NUM_CLIPS) begin
                                tab_we     = 1'b1;
                                tab_waddr  = CLIP_AW'(i_cmd.data.clip_slot);
                                tab_wstart = i_cmd.data.clip_first;
                                tab_wend   = i_cmd.data.clip_last;
                                n_valid[CLIP_AW'(i_cmd.data.clip_slot)] = 1'b1;
                            end
                        end
                        CMD_LENGTHS: begin
                            n_et = i_cmd.data.edited_length_in;
                            n_ot = i_cmd.data.original_length_in;
                        end
                        CMD_SEEK: begin
                            n_i     = '0;
                            n_acc   = '0;
                            n_off   = i_cmd.data.offset;
                            n_mode  = i_cmd.data.seek_mode;
                            n_state = ST_SUM_RD;
                        end
                        CMD_READ: begin
                            n_rem   = i_cmd.data.count;
                            n_total = '0;
                            n_n     = '0;
                            n_rfp   = {1'b0, r_fp};
                            n_state = ST_RD_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUM_RD: begin
                if (r_i < r_cc) begin
                    n_state = ST_SUM_AC;
                end else begin
                    tab_raddr = r_cc[CLIP_AW-1:0];
                    n_state   = ST_BASE;
                end
            end
            ST_SUM_AC: begin
                n_acc   = r_acc + lenx;
                n_i     = r_i + CLIP_CW'(1);
                n_state = ST_SUM_RD;
            end
            ST_BASE: begin
                if (was < 0) begin
                    n_rep = '0;
                end else if (was > ACC_W'(32'h7FFF_FFFF)) begin
                    n_rep = 31'h7FFF_FFFF;
                end else begin
                    n_rep = was[30:0];
                end
                case (r_mode)
                    SEEK_END: tgt = tgt + $signed({{(ACC_W-31){1'b0}}, r_et});
                    SEEK_CUR: tgt = tgt + was;
                    default:  ;
                endcase
                if (tgt < 0) begin
                    tgt = '0;
                end
                n_target = tgt;
                n_i      = '0;
                n_acc    = '0;
                if (r_off == 32'sd0 && r_mode == SEEK_CUR) begin
                    n_state = ST_SEEK_OUT;
                end else begin
                    n_state = ST_MAP_RD;
                end
            end
            ST_MAP_RD: begin
                n_state = (r_i < CLIP_CW'(NUM_CLIPS)) ? ST_MAP_EV : ST_MAP_END;
            end
            ST_MAP_EV: begin
                if (end_q == '0) begin
                    n_state = ST_MAP_END;
                end else if (r_target >= r_acc && r_target < pos_end) begin
                    n_fp    = addr[30:0];
                    n_cc    = r_i;
                    n_state = ST_SEEK_OUT;
                end else begin
                    n_acc      = pos_end;
                    n_last_end = end_q;
                    n_i        = r_i + CLIP_CW'(1);
                    n_state    = ST_MAP_RD;
                end
            end
            ST_MAP_END: begin
                if (r_i != '0 && {1'b0, r_last_end} == ({1'b0, r_ot} - 32'd1)
                        && r_target == $signed({{(ACC_W-31){1'b0}}, r_et})) begin
                    n_fp    = r_ot;
                    n_cc    = r_i - CLIP_CW'(1);
                    n_state = ST_SEEK_OUT;
                end else if (r_i >= CLIP_CW'(NUM_CLIPS)) begin
                    tab_raddr = CLIP_AW'(NUM_CLIPS - 1);
                    n_state   = ST_MAP_LS;
                end else begin
                    tab_we   = 1'b1;
                    n_valid[r_i[CLIP_AW-1:0]] = 1'b1;
                    n_fp     = r_ot;
                    n_cc     = r_i;
                    n_state  = ST_SEEK_OUT;
                end
            end
            ST_MAP_LS: begin
                n_fp    = start_q;
                n_cc    = CLIP_CW'(NUM_CLIPS - 1);
                n_state = ST_SEEK_OUT;
            end
            ST_SEEK_OUT: begin
                n_out       = '{position: r_rep, file_address: r_fp, clip_number: 5'(r_cc),
                                run_length: '0, last: 1'b1};
                n_out_valid = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (o_res.ready) begin
                    n_out_valid = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_RD_RD: begin
                tab_raddr = r_cc[CLIP_AW-1:0];
                if (r_rem != '0 && r_n < RUN_CW'(MAX_RUNS) && r_cc < CLIP_CW'(NUM_CLIPS)) begin
                    n_state = ST_RD_EV;
                end else begin
                    n_state = ST_RD_FIN;
                end
            end
            ST_RD_EV: begin
                if (end_q == '0 || run <= 0) begin
                    n_state = ST_RD_FIN;
                end else begin
                    buf_we    = 1'b1;
                    buf_wdata = '{total: total_new, addr: r_rfp[30:0], len: run[30:0]};
                    n_total   = total_new;
                    n_rem     = r_rem - run[30:0];
                    n_n       = r_n + RUN_CW'(1);
                    n_rfp     = rfp_new;
                    n_state   = ST_RD_RD;
                    if (rfp_new > {1'b0, end_q}) begin
                        n_cc = cc_next;
                        if (cc_next < CLIP_CW'(NUM_CLIPS)) begin
                            tab_raddr = cc_next[CLIP_AW-1:0];
                            n_state   = ST_RD_NX;
                        end
                    end
                end
            end
            ST_RD_NX: begin
                if (end_q != '0) begin
                    n_rfp = {1'b0, start_q};
                end else begin
                    n_rfp     = {1'b0, r_ot};
                    tab_we    = 1'b1;
                    tab_waddr = r_cc[CLIP_AW-1:0];
                    n_valid[r_cc[CLIP_AW-1:0]] = 1'b1;
                end
                n_state = ST_RD_RD;
            end
            ST_RD_FIN: begin
                n_fp = r_rfp[30:0];
                n_k  = '0;
                if (r_n == '0) begin
                    n_out       = '{position: '0, file_address: r_rfp[30:0],
                                    clip_number: 5'(r_cc), run_length: '0, last: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = ST_WAIT;
                end else begin
                    n_state = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                n_state = ST_EM_LD;
            end
            ST_EM_LD: begin
                n_out       = '{position: buf_q.total, file_address: buf_q.addr,
                                clip_number: 5'(r_cc), run_length: buf_q.len,
                                last: (r_k == r_n - RUN_CW'(1))};
                n_out_valid = 1'b1;
                n_state     = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (o_res.ready) begin
                    n_out_valid = 1'b0;
                    n_k         = r_k + RUN_CW'(1);
                    n_state     = (r_k + RUN_CW'(1) == r_n) ? ST_IDLE : ST_EM_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_out_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_WAIT || r_state == ST_EM_WAIT))
        else $error("result valid outside a delivery state");

    a_cc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CLIP_CW'(NUM_CLIPS))
        else $error("current clip beyond table");

    a_em_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EM_LD |=> r_out_valid)
        else $error("run not presented after buffer read");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EM_WAIT |-> (r_k < r_n && r_n <= RUN_CW'(MAX_RUNS)))
        else $error("run index outside buffered runs");
endmodule

/* rtl/elpm_ram.sv */
// elpm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module elpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* dv/tb.sv */
// tb: self-checking testbench for edit_list_position_mapper; predicts seek and read results
// from an internal model of the clip table, with random bursts, gaps and output stalls.
// Depends on elpm_pkg, elpm_in_if, elpm_out_if and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import elpm_pkg::*;

    class position_scoreboard;
        logic [30:0] cstart [NUM_CLIPS];
        logic [30:0] cend [NUM_CLIPS];
        logic [30:0] ed_total, orig_total, fpos;
        int unsigned cur;
        t_out_item pending [$];
        int errors;

        function void clear();
            for (int i = 0; i < NUM_CLIPS; i++) begin
                cstart[i] = '0;
                cend[i] = '0;
            end
            ed_total = '0;
            orig_total = '0;
            fpos = '0;
            cur = 0;
            errors = 0;
        endfunction

        function longint span(int i);
            return longint'(cend[i]) - longint'(cstart[i]) + 1;
        endfunction

        function void empty_clip(int i);
            cstart[i] = orig_total;
            cend[i] = orig_total - 31'd1;
        endfunction

        function longint edited_pos();
            longint p;
            longint s;
            p = 0;
            for (int i = 0; i < cur && i < NUM_CLIPS; i++) p += span(i);
            s = (cur < NUM_CLIPS) ? longint'(cstart[cur]) : 0;
            return p + longint'(fpos) - s;
        endfunction

        function void locate(longint target);
            int i;
            longint p;
            longint len;
            i = 0;
            p = 0;
            while (i < NUM_CLIPS && cend[i] != 0) begin
                len = span(i);
                if (target >= p && target < p + len) begin
                    fpos = 31'(longint'(cstart[i]) + target - p);
                    cur = i;
                    return;
                end
                p += len;
                i++;
            end
            if (i > 0 && longint'(cend[i-1]) == longint'(orig_total) - 1 &&
                target == longint'(ed_total)) begin
                fpos = orig_total;
                cur = i - 1;
            end else if (i >= NUM_CLIPS) begin
                fpos = cstart[NUM_CLIPS-1];
                cur = NUM_CLIPS - 1;
            end else begin
                empty_clip(i);
                fpos = orig_total;
                cur = i;
            end
        endfunction

        function t_out_item mk(longint p, longint a, longint r, bit l);
            t_out_item o;
            o.position = 31'(p);
            o.file_address = 31'(a);
            o.clip_number = 5'(cur);
            o.run_length = 31'(r);
            o.last = l;
            return o;
        endfunction

        function void note_command(t_in_item it);
            longint was, rep, target, rem, fp, total, stop, run;
            int n;
            t_out_item runs [$];
            case (it.command)
                CMD_LOAD: begin
                    if (it.clip_slot < NUM_CLIPS) begin
                        cstart[it.clip_slot] = it.clip_first;
                        cend[it.clip_slot] = it.clip_last;
                    end
                end
                CMD_LENGTHS: begin
                    ed_total = it.edited_length_in;
                    orig_total = it.original_length_in;
                end
                CMD_SEEK: begin
                    was = edited_pos();
                    rep = was < 0 ? 0 : (was > 64'h7FFFFFFF ? 64'h7FFFFFFF : was);
                    if (!(it.offset == 0 && it.seek_mode == SEEK_CUR)) begin
                        target = longint'(it.offset);
                        if (it.seek_mode == SEEK_END) target += longint'(ed_total);
                        else if (it.seek_mode == SEEK_CUR) target += was;
                        if (target < 0) target = 0;
                        locate(target);
                    end
                    pending.push_back(mk(rep, longint'(fpos), 0, 1'b1));
                end
                default: begin
                    rem = longint'(it.count);
                    fp = longint'(fpos);
                    total = 0;
                    n = 0;
                    while (rem > 0 && n < MAX_RUNS && cur < NUM_CLIPS && cend[cur] != 0) begin
                        stop = longint'(cend[cur]);
                        run = stop - fp + 1;
                        if (rem < run) run = rem;
                        if (run <= 0) break;
                        total += run;
                        runs.push_back(mk(total, fp, run, 1'b0));
                        n++;
                        rem -= run;
                        fp += run;
                        if (fp > stop) begin
                            cur++;
                            if (cur < NUM_CLIPS) begin
                                if (cend[cur] != 0) fp = longint'(cstart[cur]);
                                else begin
                                    fp = longint'(orig_total);
                                    empty_clip(cur);
                                end
                            end
                        end
                    end
                    fpos = 31'(fp);
                    if (n == 0) pending.push_back(mk(0, longint'(fpos), 0, 1'b1));
                    else begin
                        foreach (runs[k]) begin
                            runs[k].clip_number = 5'(cur);
                            runs[k].last = (k == n - 1);
                            pending.push_back(runs[k]);
                        end
                    end
                end
            endcase
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_out_item r);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("unexpected result %p", r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.position != e.position)
                report("position", longint'(r.position), longint'(e.position));
            if (r.file_address != e.file_address)
                report("file_address", longint'(r.file_address), longint'(e.file_address));
            if (r.clip_number != e.clip_number)
                report("clip_number", longint'(r.clip_number), longint'(e.clip_number));
            if (r.run_length != e.run_length)
                report("run_length", longint'(r.run_length), longint'(e.run_length));
            if (r.last != e.last) report("last", longint'(r.last), longint'(e.last));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    elpm_in_if cmd_ch ();
    elpm_out_if res_ch ();
    position_scoreboard sb = new();

    edit_list_position_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    int hold_off = 0;
    bit stall_mode = 0;
    int idle_cycles = 0;
    bit finishing = 0;

    initial begin
        cmd_ch.valid = 0;
        cmd_ch.data = '0;
        res_ch.ready = 0;
    end

    // receiver: checks results and stalls on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 0;
        end else if (stall_mode) res_ch.ready <= ($urandom_range(0, 3) == 0);
        else res_ch.ready <= ($urandom_range(0, 7) != 0);
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("edit_list_position_mapper verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) stall_mode <= ($urandom_range(0, 63) == 0) ? ~stall_mode : stall_mode;

    int burst_left = 0;

    task send(t_in_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        cmd_ch.valid <= 1;
        cmd_ch.data <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_command(it);
        burst_left--;
        if (burst_left == 0) cmd_ch.valid <= 0;
    endtask

    task drain();
        if (burst_left != 0) cmd_ch.valid <= 0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function t_in_item blank(t_cmd c);
        t_in_item it;
        it = '0;
        it.command = c;
        it.clip_slot = 5'($urandom);
        it.clip_first = 31'($urandom);
        it.clip_last = 31'($urandom);
        it.edited_length_in = 31'($urandom);
        it.original_length_in = 31'($urandom);
        it.offset = 32'($urandom);
        it.seek_mode = t_seek_mode'($urandom_range(0, 3));
        it.count = 31'($urandom);
        return it;
    endfunction

    task load(int slot, int first, int lst);
        t_in_item it;
        it = blank(CMD_LOAD);
        it.clip_slot = 5'(slot);
        it.clip_first = 31'(first);
        it.clip_last = 31'(lst);
        send(it);
    endtask

    task lengths(longint e, longint o);
        t_in_item it;
        it = blank(CMD_LENGTHS);
        it.edited_length_in = 31'(e);
        it.original_length_in = 31'(o);
        send(it);
    endtask

    task seek(longint off, t_seek_mode m);
        t_in_item it;
        it = blank(CMD_SEEK);
        it.offset = 32'(off);
        it.seek_mode = m;
        send(it);
    endtask

    task read(longint n);
        t_in_item it;
        it = blank(CMD_READ);
        it.count = 31'(n);
        send(it);
    endtask

    // build a consistent edit list of nclips clips over a stored file
    task build_list(int nclips);
        int base, len, tot;
        base = $urandom_range(0, 50);
        tot = 0;
        for (int i = 0; i < nclips; i++) begin
            len = $urandom_range(0, 40);
            load(i, base, base + len - 1);
            tot += len;
            base += len + $urandom_range(0, 20);
        end
        if (nclips < NUM_CLIPS) load(nclips, $urandom, 0);
        lengths(tot, base + $urandom_range(0, 1) * 0);
    endtask

    int unsigned pick;

    initial begin
        sb.clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        read(5);
        seek(0, SEEK_CUR);
        seek(10, SEEK_BEGIN);
        load(0, 100, 199);
        load(1, 300, 349);
        lengths(150, 350);
        seek(-32'sd5, SEEK_BEGIN);
        seek(150, SEEK_BEGIN);
        seek(0, SEEK_END);
        seek(-32'sd40, SEEK_END);
        seek(7, SEEK_CUR);
        seek(32'sh7FFFFFFF, SEEK_RSVD);
        seek(32'sh80000000, SEEK_CUR);
        seek(90, SEEK_BEGIN);
        read(0);
        read(30);
        read(31'h7FFFFFFF);
        seek(0, SEEK_CUR);
        load(31, 31'h7FFFFFFF, 31'h7FFFFFFF);
        load(2, 31'h7FFFFFFF, 31'h7FFFFFFE);
        lengths(31'h7FFFFFFF, 31'h7FFFFFFF);
        seek(1000, SEEK_BEGIN);
        read(3);
        drain();
        for (int i = 0; i < NUM_CLIPS; i++) load(i, i * 4, i * 4 + 1);
        lengths(64, 128);
        seek(0, SEEK_BEGIN);
        read(31'h7FFFFFFF);
        read(4);
        seek(0, SEEK_CUR);
        seek(500, SEEK_BEGIN);

        // long receiver hold-off while commands keep coming
        hold_off = 400;
        for (int i = 0; i < 6; i++) read(31'h7FFFFFFF);
        drain();

        for (int n = 0; n < 310; ) begin
            int nc;
            if ($urandom_range(0, 19) == 0) begin
                drain();
                nc = $urandom_range(0, NUM_CLIPS);
                build_list(nc);
                n += nc + 2;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) seek($urandom_range(0, 12) == 0 ? longint'(int'($urandom))
                                : longint'($urandom_range(0, 900)) - 100,
                                t_seek_mode'($urandom_range(0, 3)));
            else if (pick < 80) read($urandom_range(0, 9) == 0 ? $urandom
                                     : $urandom_range(0, 120));
            else if (pick < 90) begin
                t_in_item it;
                it = blank(CMD_LOAD);
                if ($urandom_range(0, 1)) begin
                    it.clip_first = 31'($urandom_range(0, 500));
                    it.clip_last = 31'(it.clip_first + $urandom_range(0, 40));
                end
                send(it);
            end else if (pick < 95) send(blank(CMD_LENGTHS));
            else seek(0, SEEK_CUR);
            n++;
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("edit_list_position_mapper verification clean");
        else
            $display("edit_list_position_mapper verification failed");
        $finish;
    end
endmodule
